// File: rtl/mcv_pkg.sv
// Package: layer sizes, derived widths, request codes and queue command type.
package mcv_pkg;

	localparam int IN_DIM       = 32;
	localparam int KERNEL_DIM   = 5;
	localparam int NUM_CHANNELS = 16;
	localparam int NUM_FILTERS  = 16;
	localparam int STEP         = 1;
	localparam int DATA_WIDTH   = 16;

	localparam int OUT_DIM = (IN_DIM >= KERNEL_DIM) ? ((IN_DIM - KERNEL_DIM) / STEP + 1) : 0;
	localparam int IN_SIZE = IN_DIM * IN_DIM * NUM_CHANNELS;
	localparam int W_SIZE  = KERNEL_DIM * KERNEL_DIM * NUM_CHANNELS * NUM_FILTERS;

	localparam int IN_AW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
	localparam int W_AW  = (W_SIZE > 1) ? $clog2(W_SIZE) : 1;
	localparam int F_AW  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

	localparam int RUN_LEN    = KERNEL_DIM * NUM_CHANNELS;
	localparam int RUN_W      = (RUN_LEN > 1) ? $clog2(RUN_LEN) : 1;
	localparam int KI_W       = (KERNEL_DIM > 1) ? $clog2(KERNEL_DIM) : 1;
	localparam int ROW_STRIDE = IN_DIM * NUM_CHANNELS;

	localparam int REQ_W  = 2;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 5;
	localparam int CH_W   = 4;
	localparam int FILT_W = 4;
	localparam int VAL_W  = 16;
	localparam int OUT_W  = 48;
	localparam int PROD_W = 2 * DATA_WIDTH;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [REQ_W-1:0] REQ_WR_IN = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WR_W  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WR_B  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_RD    = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]             kind;
		logic [IN_AW-1:0]             in_addr;
		logic [W_AW-1:0]              w_addr;
		logic [F_AW-1:0]              filt;
		logic signed [DATA_WIDTH-1:0] data;
	} cmd_t;

endpackage

// File: rtl/mcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcv_ram #(
	parameter int W = 16,
	parameter int D = 16
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                       wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                       rdata
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/mcv_front.sv
// Front end: accepts request beats, range-checks them and forms store addresses.
module mcv_front import mcv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [ROW_W-1:0]        row,
	input  logic [COL_W-1:0]        col,
	input  logic [CH_W-1:0]         channel,
	input  logic [FILT_W-1:0]       filter,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    q_full,
	output logic                    push,
	output cmd_t                    push_cmd
);
	cmd_t        nxt;
	logic        keep;
	logic [31:0] r32, c32, ch32, f32;
	logic        cmd_v_s1;
	cmd_t        cmd_s1;

	assign r32  = 32'(row);
	assign c32  = 32'(col);
	assign ch32 = 32'(channel);
	assign f32  = 32'(filter);

	always_comb begin
		nxt      = '0;
		keep     = 1'b0;
		nxt.kind = req_type;
		nxt.data = DATA_WIDTH'(value);
		case (req_type)
			REQ_WR_IN: begin
				keep = (r32 < IN_DIM) && (c32 < IN_DIM) && (ch32 < NUM_CHANNELS);
				nxt.in_addr = IN_AW'((r32 * IN_DIM + c32) * NUM_CHANNELS + ch32);
			end
			REQ_WR_W: begin
				keep = (r32 < KERNEL_DIM) && (c32 < KERNEL_DIM) && (ch32 < NUM_CHANNELS)
					&& (f32 < NUM_FILTERS);
				nxt.w_addr = W_AW'(((r32 * KERNEL_DIM + c32) * NUM_CHANNELS + ch32)
					* NUM_FILTERS + f32);
			end
			REQ_WR_B: begin
				keep = (f32 < NUM_FILTERS);
				nxt.filt = F_AW'(filter);
			end
			REQ_RD: begin
				keep = (r32 < OUT_DIM) && (c32 < OUT_DIM) && (f32 < NUM_FILTERS);
				nxt.in_addr = IN_AW'((r32 * STEP * IN_DIM + c32 * STEP) * NUM_CHANNELS);
				nxt.w_addr = W_AW'(filter);
				nxt.filt = F_AW'(filter);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req_stall = cmd_v_s1 && q_full;
	assign push      = cmd_v_s1 && !q_full;
	assign push_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			cmd_v_s1 <= keep;
		end else if (push) begin
			cmd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1 <= nxt;
		end
	end
endmodule

// File: rtl/mcv_queue.sv
// Short command queue between front end and compute back end.
module mcv_queue import mcv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);
	cmd_t            ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full      = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end
endmodule

// File: rtl/mcv_back.sv
// Back end: sample, weight and bias stores plus the multiply-accumulate sequencer.
module mcv_back import mcv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  cmd_t                    q_cmd,
	output logic                    q_pop,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [OUT_W-1:0] output_value
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(RUN_LEN - 1);
	localparam logic [KI_W-1:0]  KI_LAST  = KI_W'(KERNEL_DIM - 1);

	logic [1:0]                state_q;
	logic                      rd_start, issue, last_iss, fin_load;
	logic                      in_we, w_we, b_we;
	logic [IN_AW-1:0]          iaddr_q, row_q;
	logic [W_AW-1:0]           waddr_q;
	logic [RUN_W-1:0]          run_q;
	logic [KI_W-1:0]           ki_q;
	logic [DATA_WIDTH-1:0]     x_s1, w_s1, b_s1;
	logic                      rd_v_s1, last_s1, bias_v_s1;
	logic                      mul_v_s2, last_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [OUT_W-1:0]   acc_q, out_q;
	logic                      out_v_q;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign rd_start = q_pop && (q_cmd.kind == REQ_RD);
	assign in_we    = q_pop && (q_cmd.kind == REQ_WR_IN);
	assign w_we     = q_pop && (q_cmd.kind == REQ_WR_W);
	assign b_we     = q_pop && (q_cmd.kind == REQ_WR_B);
	assign issue    = (state_q == ST_RUN);
	assign last_iss = issue && (run_q == RUN_LAST) && (ki_q == KI_LAST);
	assign fin_load = (state_q == ST_FIN) && (!out_v_q || !rsp_stall);

	mcv_ram #(.W(DATA_WIDTH), .D(IN_SIZE)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (q_cmd.in_addr),
		.wdata (q_cmd.data),
		.raddr (iaddr_q),
		.rdata (x_s1)
	);

	mcv_ram #(.W(DATA_WIDTH), .D(W_SIZE)) u_w_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (q_cmd.w_addr),
		.wdata (q_cmd.data),
		.raddr (waddr_q),
		.rdata (w_s1)
	);

	mcv_ram #(.W(DATA_WIDTH), .D(NUM_FILTERS)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (q_cmd.filt),
		.wdata (q_cmd.data),
		.raddr (q_cmd.filt),
		.rdata (b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_v_s1   <= 1'b0;
			last_s1   <= 1'b0;
			bias_v_s1 <= 1'b0;
			mul_v_s2  <= 1'b0;
			last_s2   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			rd_v_s1   <= issue;
			last_s1   <= last_iss;
			bias_v_s1 <= rd_start;
			mul_v_s2  <= rd_v_s1;
			last_s2   <= last_s1;
			if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			if (fin_load) begin
				out_v_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (rd_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_iss) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mul_v_s2 && last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window walk: channels and columns of one kernel row are contiguous
	always_ff @(posedge clk) begin
		if (rd_start) begin
			iaddr_q <= q_cmd.in_addr;
			row_q   <= q_cmd.in_addr;
			waddr_q <= q_cmd.w_addr;
			run_q   <= '0;
			ki_q    <= '0;
		end else if (issue) begin
			waddr_q <= waddr_q + W_AW'(NUM_FILTERS);
			if (run_q == RUN_LAST) begin
				run_q <= '0;
				if (ki_q != KI_LAST) begin
					ki_q    <= ki_q + 1'b1;
					row_q   <= row_q + IN_AW'(ROW_STRIDE);
					iaddr_q <= row_q + IN_AW'(ROW_STRIDE);
				end
			end else begin
				run_q   <= run_q + 1'b1;
				iaddr_q <= iaddr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(x_s1) * $signed(w_s1);
		if (bias_v_s1) begin
			acc_q <= OUT_W'($signed(b_s1));
		end else if (mul_v_s2) begin
			acc_q <= acc_q + OUT_W'(prod_s2);
		end
		if (fin_load) begin
			out_q <= acc_q;
		end
	end

	assign rsp_valid    = out_v_q;
	assign output_value = out_q;
endmodule

// File: rtl/multichannel_conv2d_bias_core.sv
// Top level: strided multi-channel 2-D convolution with per-filter bias.
// Request channel (req_valid/req_stall): each beat writes one input sample
// (req_type 0), one kernel weight (1) or one filter bias (2), or asks for one
// output (3) at output row, column and filter. Out-of-range beats are taken
// and dropped; writes never answer.
// Response channel (rsp_valid/rsp_stall): one beat of output_value per
// in-range read, in request order.
// Requests pass a registered decode stage and a four-entry command queue; the
// back end runs one command at a time. A write retires as it is popped. A read
// streams KERNEL_DIM*KERNEL_DIM*NUM_CHANNELS (400) operand pairs, one per
// cycle, through a single multiply-accumulate fed by one read port on each of
// the sample and weight memories, so a read holds the back end until its last
// product is accumulated and its result is loaded into the output register.
// Reset clears control only; store contents are undefined until written.
// While rsp_stall holds, the result stays in the output register, writes
// queued behind it still retire, and the next read waits at its last step;
// once the queue fills, req_stall rises.
module multichannel_conv2d_bias_core import mcv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [ROW_W-1:0]        row,
	input  logic [COL_W-1:0]        col,
	input  logic [CH_W-1:0]         channel,
	input  logic [FILT_W-1:0]       filter,
	input  logic signed [VAL_W-1:0] value,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [OUT_W-1:0] output_value
);
	logic push, q_full, q_pop, q_valid;
	cmd_t push_cmd, q_cmd;

	mcv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.row       (row),
		.col       (col),
		.channel   (channel),
		.filter    (filter),
		.value     (value),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	mcv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_cmd)
	);

	mcv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.output_value (output_value)
	);
endmodule

// File: rtl/mcv_checker.sv
// Port-level checker for the convolution core, bound to the top level.
module mcv_checker import mcv_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_stall,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic signed [OUT_W-1:0] output_value
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(output_value))
		else $error("stalled response changed");

	a_rst_rsp: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("response beat present out of reset");

	a_rst_stall: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_stall)
		else $error("request stall raised out of reset");
endmodule

bind multichannel_conv2d_bias_core mcv_checker u_mcv_checker (.*);

// File: bench/multichannel_conv2d_bias_core_tb.sv
// Testbench for multichannel_conv2d_bias_core: stores preload, directed reads, backpressure, random traffic.
module multichannel_conv2d_bias_core_tb;
	import mcv_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int TAIL_CYCLES    = 450;

	// reads stay inside a small corner of the output grid, on one filter
	localparam int REG_OUT   = 2;
	localparam int REG_IN    = (REG_OUT - 1) * STEP + KERNEL_DIM;
	localparam int READ_FILT = 0;

	localparam int MOST_NEG = -(1 << (VAL_W - 1));
	localparam int MOST_POS = (1 << (VAL_W - 1)) - 1;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic [REQ_W-1:0]        req_type = REQ_WR_IN;
	logic [ROW_W-1:0]        row = '0;
	logic [COL_W-1:0]        col = '0;
	logic [CH_W-1:0]         channel = '0;
	logic [FILT_W-1:0]       filter = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic signed [OUT_W-1:0] output_value;

	multichannel_conv2d_bias_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.row(row),
		.col(col),
		.channel(channel),
		.filter(filter),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.output_value(output_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the layer stores
	logic signed [DATA_WIDTH-1:0] sample_mem [IN_SIZE];
	logic signed [DATA_WIDTH-1:0] weight_mem [W_SIZE];
	logic signed [DATA_WIDTH-1:0] bias_mem [NUM_FILTERS];
	logic signed [OUT_W-1:0]      sums_due [$];

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_asks = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic signed [OUT_W-1:0] want_sum;

	function automatic logic signed [OUT_W-1:0] conv_sum(input int r, input int c, input int f);
		longint acc;
		int     ir;
		int     ic;
		acc = bias_mem[f];
		for (int i = 0; i < KERNEL_DIM; i++) begin
			for (int j = 0; j < KERNEL_DIM; j++) begin
				ir = r * STEP + i;
				ic = c * STEP + j;
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					acc += longint'(weight_mem[((i * KERNEL_DIM + j) * NUM_CHANNELS + k)
						* NUM_FILTERS + f])
						* longint'(sample_mem[(ir * IN_DIM + ic) * NUM_CHANNELS + k]);
				end
			end
		end
		return acc[OUT_W-1:0];
	endfunction

	function automatic void note_beat(input logic [REQ_W-1:0] kind, input int r, input int c,
		input int ch, input int f, input logic signed [VAL_W-1:0] v);
		logic signed [DATA_WIDTH-1:0] word;
		word = v;
		case (kind)
			REQ_WR_IN: begin
				if (r < IN_DIM && c < IN_DIM && ch < NUM_CHANNELS)
					sample_mem[(r * IN_DIM + c) * NUM_CHANNELS + ch] = word;
			end
			REQ_WR_W: begin
				if (r < KERNEL_DIM && c < KERNEL_DIM && ch < NUM_CHANNELS && f < NUM_FILTERS)
					weight_mem[((r * KERNEL_DIM + c) * NUM_CHANNELS + ch) * NUM_FILTERS + f] = word;
			end
			REQ_WR_B: begin
				if (f < NUM_FILTERS)
					bias_mem[f] = word;
			end
			default: begin
				if (r < OUT_DIM && c < OUT_DIM && f < NUM_FILTERS)
					sums_due.push_back(conv_sum(r, c, f));
			end
		endcase
	endfunction

	task automatic send_beat(input logic [REQ_W-1:0] kind, input int r, input int c,
		input int ch, input int f, input int v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		row <= ROW_W'(r);
		col <= COL_W'(c);
		channel <= CH_W'(ch);
		filter <= FILT_W'(f);
		value <= VAL_W'(v);
		do @(posedge clk); while (req_stall);
		note_beat(kind, int'(row), int'(col), int'(channel), int'(filter), value);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sums_due.size() != 0);
	endtask

	task automatic run_traffic(input int count);
		int               sent;
		int               n;
		int               r;
		int               c;
		logic [REQ_W-1:0] k;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 80) begin
				// writes into one window, then read it back
				r = $urandom_range(REG_OUT - 1);
				c = $urandom_range(REG_OUT - 1);
				n = $urandom_range(6);
				repeat (n) begin
					case ($urandom_range(2))
						0: send_beat(REQ_WR_IN, r * STEP + $urandom_range(KERNEL_DIM - 1),
							c * STEP + $urandom_range(KERNEL_DIM - 1),
							$urandom_range(NUM_CHANNELS - 1), $urandom(), $urandom());
						1: send_beat(REQ_WR_W, $urandom_range(KERNEL_DIM - 1),
							$urandom_range(KERNEL_DIM - 1), $urandom_range(NUM_CHANNELS - 1),
							READ_FILT, $urandom());
						default: send_beat(REQ_WR_B, $urandom(), $urandom(), $urandom(),
							READ_FILT, $urandom());
					endcase
				end
				send_beat(REQ_RD, r, c, $urandom(), READ_FILT, $urandom());
				sent += n + 1;
			end else begin
				// stray beat; a read lands outside the output grid
				k = REQ_W'($urandom());
				if (k == REQ_RD)
					send_beat(REQ_RD, $urandom_range((1 << ROW_W) - 1, OUT_DIM), $urandom(),
						$urandom(), $urandom(), $urandom());
				else
					send_beat(k, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				sent++;
			end
		end
	endtask

	task automatic test_preload();
		int v;
		for (int r = 0; r < REG_IN; r++) begin
			for (int c = 0; c < REG_IN; c++) begin
				for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
					if (r < KERNEL_DIM && c < KERNEL_DIM)
						v = MOST_NEG;
					else
						v = MOST_POS;
					send_beat(REQ_WR_IN, r, c, ch, $urandom(), v);
				end
			end
		end
		for (int i = 0; i < KERNEL_DIM; i++) begin
			for (int j = 0; j < KERNEL_DIM; j++) begin
				for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
					send_beat(REQ_WR_W, i, j, ch, READ_FILT, MOST_NEG);
				end
			end
		end
		for (int f = 0; f < NUM_FILTERS; f++) begin
			if (f == READ_FILT)
				v = MOST_POS;
			else
				v = $urandom();
			send_beat(REQ_WR_B, $urandom(), $urandom(), $urandom(), f, v);
		end
	endtask

	task automatic test_directed();
		// largest positive sum, then windows mixing both signs
		send_beat(REQ_RD, 0, 0, $urandom(), READ_FILT, $urandom());
		send_beat(REQ_RD, 0, REG_OUT - 1, $urandom(), READ_FILT, $urandom());
		send_beat(REQ_RD, REG_OUT - 1, 0, $urandom(), READ_FILT, $urandom());
		send_beat(REQ_RD, REG_OUT - 1, REG_OUT - 1, $urandom(), READ_FILT, $urandom());
		// out-of-range reads and weight writes are dropped, then an in-range far-corner sample write
		send_beat(REQ_RD, OUT_DIM, 0, $urandom(), READ_FILT, $urandom());
		send_beat(REQ_RD, 0, OUT_DIM, $urandom(), 2, $urandom());
		send_beat(REQ_RD, '1, '1, '1, '1, $urandom());
		send_beat(REQ_WR_W, KERNEL_DIM, 0, 0, READ_FILT, MOST_POS);
		send_beat(REQ_WR_W, 0, '1, '1, '1, MOST_POS);
		send_beat(REQ_WR_W, '1, '1, '1, '1, MOST_NEG);
		send_beat(REQ_WR_IN, '1, '1, '1, $urandom(), MOST_POS);
		// corner writes then an immediate read of the same window
		send_beat(REQ_WR_IN, REG_IN - 1, REG_IN - 1, '1, $urandom(), MOST_POS);
		send_beat(REQ_WR_IN, REG_IN - 1, REG_IN - 1, 0, $urandom(), MOST_NEG);
		send_beat(REQ_WR_W, KERNEL_DIM - 1, KERNEL_DIM - 1, '1, READ_FILT, MOST_POS);
		send_beat(REQ_WR_W, KERNEL_DIM - 1, KERNEL_DIM - 1, 0, READ_FILT, '1);
		send_beat(REQ_WR_B, $urandom(), $urandom(), $urandom(), READ_FILT, MOST_NEG);
		send_beat(REQ_RD, REG_OUT - 1, REG_OUT - 1, $urandom(), READ_FILT, $urandom());
		send_beat(REQ_WR_B, $urandom(), $urandom(), $urandom(), READ_FILT, '0);
		send_beat(REQ_WR_IN, 0, 0, 0, $urandom(), '0);
		send_beat(REQ_RD, 0, 0, $urandom(), READ_FILT, $urandom());
		send_beat(REQ_RD, 0, 0, $urandom(), READ_FILT, $urandom());
	endtask

	task automatic test_backpressure();
		wait_drained();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_asks <= hold_asks + 1;
		send_beat(REQ_RD, REG_OUT - 1, 0, $urandom(), READ_FILT, $urandom());
		for (int k = 0; k < 12; k++) begin
			if (k % 4 == 3)
				send_beat(REQ_RD, $urandom_range(REG_OUT - 1), $urandom_range(REG_OUT - 1),
					$urandom(), READ_FILT, $urandom());
			else
				send_beat(REQ_WR_IN, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		end
		wait_drained();
	endtask

	task automatic test_idling();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		run_traffic(130);
		wait_drained();
		send_idle_pct = 47;
		run_traffic(130);
		wait_drained();
		send_idle_pct = 0;
		rsp_stall_pct = 47;
		run_traffic(130);
		wait_drained();
		send_idle_pct = 16;
		rsp_stall_pct = 16;
		run_traffic(100);
	endtask

	task automatic finish_run();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	endtask

	// response side: check each beat, then pick the next stall
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (sums_due.size() == 0) begin
				$display("%0t: output_value %0d arrived with none outstanding", $time,
					output_value);
				mismatches++;
			end else begin
				want_sum = sums_due.pop_front();
				if (output_value !== want_sum) begin
					$display("%0t: output_value mismatch, expected %0d, actual %0d", $time,
						want_sum, output_value);
					mismatches++;
				end
			end
		end
		if (hold_asks != hold_served) begin
			hold_served <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_preload();
		test_directed();
		test_backpressure();
		test_idling();
		finish_run();
	end

endmodule

// File: filelist.f
rtl/mcv_pkg.sv
rtl/mcv_ram.sv
rtl/mcv_front.sv
rtl/mcv_queue.sv
rtl/mcv_back.sv
rtl/multichannel_conv2d_bias_core.sv
rtl/mcv_checker.sv
bench/multichannel_conv2d_bias_core_tb.sv
